@@ hdl/i2cbe_pkg.sv @@
// Shared types and codes for the I2C master bit engine.
// No dependencies; every other file imports this package.
package i2cbe_pkg;

   localparam int unsigned KindWidth  = 3;
   localparam int unsigned PhaseWidth = 5;
   localparam int unsigned TickWidth  = 16;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CountWidth = 4;

   // Number of data bits in one byte transfer
   localparam logic [CountWidth-1:0] BitsPerByte = 4'd8;

   // Command codes carried by an input beat
   localparam logic [KindWidth-1:0] KIND_TICK  = 3'd0;
   localparam logic [KindWidth-1:0] KIND_START = 3'd1;
   localparam logic [KindWidth-1:0] KIND_WRITE = 3'd2;
   localparam logic [KindWidth-1:0] KIND_READ  = 3'd3;
   localparam logic [KindWidth-1:0] KIND_STOP  = 3'd4;

   // Line phases of the sequencer
   localparam logic [PhaseWidth-1:0] PH_IDLE    = 5'd0;
   localparam logic [PhaseWidth-1:0] PH_ST_A    = 5'd1;
   localparam logic [PhaseWidth-1:0] PH_ST_B    = 5'd2;
   localparam logic [PhaseWidth-1:0] PH_ST_C    = 5'd3;
   localparam logic [PhaseWidth-1:0] PH_ST_D    = 5'd4;
   localparam logic [PhaseWidth-1:0] PH_W_SET   = 5'd5;
   localparam logic [PhaseWidth-1:0] PH_W_HIGH  = 5'd6;
   localparam logic [PhaseWidth-1:0] PH_W_LOW   = 5'd7;
   localparam logic [PhaseWidth-1:0] PH_WA_SET  = 5'd8;
   localparam logic [PhaseWidth-1:0] PH_WA_HIGH = 5'd9;
   localparam logic [PhaseWidth-1:0] PH_WA_LOW  = 5'd10;
   localparam logic [PhaseWidth-1:0] PH_R_PREP  = 5'd11;
   localparam logic [PhaseWidth-1:0] PH_R_HIGH  = 5'd12;
   localparam logic [PhaseWidth-1:0] PH_R_LOW   = 5'd13;
   localparam logic [PhaseWidth-1:0] PH_RA_SET  = 5'd14;
   localparam logic [PhaseWidth-1:0] PH_RA_HIGH = 5'd15;
   localparam logic [PhaseWidth-1:0] PH_RA_LOW  = 5'd16;
   localparam logic [PhaseWidth-1:0] PH_SP_A    = 5'd17;
   localparam logic [PhaseWidth-1:0] PH_SP_B    = 5'd18;
   localparam logic [PhaseWidth-1:0] PH_SP_C    = 5'd19;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic [ByteWidth-1:0] data_byte;
      logic                 ack_to_send;
      logic                 sda_line;
   } req_beat_type;

   // Input register contents handed to the sequencer
   typedef struct packed {
      logic         valid;
      req_beat_type beat;
   } in_stage_type;

   typedef struct packed {
      logic                 scl_level;
      logic                 sda_release;
      logic                 busy_res;
      logic                 done_res;
      logic [ByteWidth-1:0] byte_read;
      logic                 slave_ack;
      logic                 cmd_rejected;
   } rsp_beat_type;

endpackage

@@ hdl/i2cbe_in_stage.sv @@
// Input register of the I2C master bit engine.
// Depends on i2cbe_pkg.
module i2cbe_in_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  i2cbe_pkg::req_beat_type req_beat,
   input  logic                    advance,
   output i2cbe_pkg::in_stage_type stage
);
   import i2cbe_pkg::*;

   logic         valid_ff, valid_in;
   req_beat_type beat_ff, beat_in;
   logic         accept;

   // Take a beat when empty or when the held beat moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (accept) begin
         valid_in = 1'b1;
         beat_in  = req_beat;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign stage.valid = valid_ff;
   assign stage.beat  = beat_ff;

endmodule

@@ hdl/i2cbe_seq.sv @@
// Line sequencer of the I2C master bit engine: state, one step per beat,
// and the result register. Depends on i2cbe_pkg.
module i2cbe_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [i2cbe_pkg::TickWidth-1:0]    csr_wr_data,
   input  i2cbe_pkg::in_stage_type            stage,
   output logic                               advance,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output i2cbe_pkg::rsp_beat_type            rsp_beat
);
   import i2cbe_pkg::*;

   logic [TickWidth-1:0]  period_ff, period_in;
   logic [PhaseWidth-1:0] phase_ff, phase_in;
   logic [CountWidth-1:0] bit_count_ff, bit_count_in;
   logic [ByteWidth-1:0]  shift_ff, shift_in;
   logic [TickWidth-1:0]  tick_ff, tick_in;
   logic                  ack_mode_ff, ack_mode_in;
   logic                  ack_seen_ff, ack_seen_in;
   logic [ByteWidth-1:0]  read_value_ff, read_value_in;
   logic                  scl_ff, scl_in;
   logic                  sda_ff, sda_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_beat_type          rsp_ff, rsp_in;

   logic [TickWidth-1:0]  limit;
   logic [PhaseWidth-1:0] enter;
   logic                  do_enter;
   logic                  done;
   logic                  rejected;
   logic [CountWidth-1:0] count_inc;
   req_beat_type          beat;

   assign beat      = stage.beat;
   assign advance   = stage.valid && (!rsp_valid_ff || rsp_ready);
   assign limit     = (period_ff == '0) ? {{(TickWidth-1){1'b0}}, 1'b1} : period_ff;
   assign count_inc = bit_count_ff + 1'b1;
   assign period_in = csr_wr_en ? csr_wr_data : period_ff;

   // Phase transition, then drive the levels of the entered phase
   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      tick_in       = tick_ff;
      ack_mode_in   = ack_mode_ff;
      ack_seen_in   = ack_seen_ff;
      read_value_in = read_value_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      enter         = PH_IDLE;
      do_enter      = 1'b0;
      done          = 1'b0;
      rejected      = 1'b0;

      if (advance) begin
         if (phase_ff == PH_IDLE) begin
            unique case (beat.kind)
               KIND_START: begin
                  shift_in     = beat.data_byte;
                  bit_count_in = '0;
                  enter        = PH_ST_A;
                  do_enter     = 1'b1;
               end
               KIND_WRITE: begin
                  shift_in     = beat.data_byte;
                  bit_count_in = '0;
                  enter        = PH_W_SET;
                  do_enter     = 1'b1;
               end
               KIND_READ: begin
                  ack_mode_in  = beat.ack_to_send;
                  shift_in     = '0;
                  bit_count_in = '0;
                  enter        = PH_R_PREP;
                  do_enter     = 1'b1;
               end
               KIND_STOP: begin
                  enter    = PH_SP_A;
                  do_enter = 1'b1;
               end
               default: ;
            endcase
         end else begin
            rejected = (beat.kind != KIND_TICK);
            if (tick_ff >= limit) begin
               do_enter = 1'b1;
               unique case (phase_ff)
                  PH_ST_A:    enter = PH_ST_B;
                  PH_ST_B:    enter = PH_ST_C;
                  PH_ST_C:    enter = PH_ST_D;
                  PH_ST_D:    enter = PH_W_SET;
                  PH_W_SET:   enter = PH_W_HIGH;
                  PH_W_HIGH:  enter = PH_W_LOW;
                  PH_W_LOW: begin
                     shift_in     = {shift_ff[ByteWidth-2:0], 1'b0};
                     bit_count_in = count_inc;
                     enter        = (count_inc >= BitsPerByte) ? PH_WA_SET : PH_W_SET;
                  end
                  PH_WA_SET:  enter = PH_WA_HIGH;
                  PH_WA_HIGH: begin
                     ack_seen_in = beat.sda_line;
                     enter       = PH_WA_LOW;
                  end
                  PH_R_PREP:  enter = PH_R_HIGH;
                  PH_R_HIGH: begin
                     shift_in     = {shift_ff[ByteWidth-2:0], beat.sda_line};
                     bit_count_in = count_inc;
                     enter        = PH_R_LOW;
                  end
                  PH_R_LOW: begin
                     if (bit_count_ff >= BitsPerByte) begin
                        read_value_in = shift_ff;
                        enter         = PH_RA_SET;
                     end else begin
                        enter = PH_R_HIGH;
                     end
                  end
                  PH_RA_SET:  enter = PH_RA_HIGH;
                  PH_RA_HIGH: enter = PH_RA_LOW;
                  PH_SP_A:    enter = PH_SP_B;
                  PH_SP_B:    enter = PH_SP_C;
                  default: begin
                     // last phase of a sequence: drop back to idle
                     do_enter = 1'b0;
                     phase_in = PH_IDLE;
                     tick_in  = '0;
                     done     = 1'b1;
                  end
               endcase
            end else begin
               tick_in = tick_ff + 1'b1;
            end
         end

         if (do_enter) begin
            phase_in = enter;
            tick_in  = {{(TickWidth-1){1'b0}}, 1'b1};
            unique case (enter)
               PH_ST_A, PH_WA_SET, PH_SP_C:
                  sda_in = 1'b1;
               PH_ST_C, PH_SP_A:
                  sda_in = 1'b0;
               PH_ST_B, PH_W_HIGH, PH_WA_HIGH, PH_R_HIGH, PH_RA_HIGH, PH_SP_B:
                  scl_in = 1'b1;
               PH_ST_D, PH_W_LOW, PH_WA_LOW, PH_R_LOW, PH_RA_LOW:
                  scl_in = 1'b0;
               PH_W_SET:
                  sda_in = shift_in[ByteWidth-1];
               PH_R_PREP: begin
                  scl_in = 1'b0;
                  sda_in = 1'b1;
               end
               PH_RA_SET:
                  sda_in = !ack_mode_ff;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in        = 1'b1;
         rsp_in.scl_level    = scl_in;
         rsp_in.sda_release  = sda_in;
         rsp_in.busy_res     = (phase_in != PH_IDLE);
         rsp_in.done_res     = done;
         rsp_in.byte_read    = read_value_in;
         rsp_in.slave_ack    = ack_seen_in;
         rsp_in.cmd_rejected = rejected;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= {{(TickWidth-1){1'b0}}, 1'b1};
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         tick_ff       <= '0;
         ack_mode_ff   <= 1'b0;
         ack_seen_ff   <= 1'b1;
         read_value_ff <= '0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         period_ff     <= period_in;
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         tick_ff       <= tick_in;
         ack_mode_ff   <= ack_mode_in;
         ack_seen_ff   <= ack_seen_in;
         read_value_ff <= read_value_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_ff;

endmodule

@@ hdl/i2c_master_bit_engine.sv @@
// I2C master bit engine top level: one tick or command beat in, one status beat out.
// Beats pass the input register and then the result register; a held rsp stalls both.
// Throughput: 1 beat per cycle unless stalled; the sequencer state advances once per beat.
// Reset (synchronous, active high): idle, SCL and SDA released high, slave_ack 1,
// phase length 1 tick, both pipeline registers empty.
// Depends on i2cbe_pkg, i2cbe_in_stage and i2cbe_seq.
module i2c_master_bit_engine (
   input  logic        clock,
   input  logic        reset,
   // configuration: length of each line phase in ticks
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // tick and command beats
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic        req_ack_to_send,
   input  logic        req_sda_line,
   // line levels and status beats
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_level,
   output logic        rsp_sda_release,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_byte_read,
   output logic        rsp_slave_ack,
   output logic        rsp_cmd_rejected
);
   import i2cbe_pkg::*;

   req_beat_type req_beat;
   in_stage_type stage;
   rsp_beat_type rsp_beat;
   logic         advance;

   // Bundle the request fields into one beat
   assign req_beat.kind        = req_kind;
   assign req_beat.data_byte   = req_data_byte;
   assign req_beat.ack_to_send = req_ack_to_send;
   assign req_beat.sda_line    = req_sda_line;

   // Input register; refills in the same cycle its beat moves on
   i2cbe_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_beat  (req_beat),
      .advance   (advance),
      .stage     (stage)
   );

   // Sequencer: steps the line phases once per beat and holds the result
   i2cbe_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stage       (stage),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_beat    (rsp_beat)
   );

   // Unpack the status beat onto the result ports
   assign rsp_scl_level    = rsp_beat.scl_level;
   assign rsp_sda_release  = rsp_beat.sda_release;
   assign rsp_busy_res     = rsp_beat.busy_res;
   assign rsp_done_res     = rsp_beat.done_res;
   assign rsp_byte_read    = rsp_beat.byte_read;
   assign rsp_slave_ack    = rsp_beat.slave_ack;
   assign rsp_cmd_rejected = rsp_beat.cmd_rejected;

endmodule
